// ===== rtl/elc_pkg.sv =====
// elc_pkg: types, codes and small floor helpers for the elevator controller
// used by elc_step and elevator_controller; depends on nothing else
`default_nettype none

package elc_pkg;

   localparam int FLOORS      = 4;
   localparam int FLOOR_IDX_W = $clog2(FLOORS);
   localparam int TICKS_W     = 16;

   localparam logic [TICKS_W-1:0] DOOR_TICKS_RESET = TICKS_W'(3000);

   localparam logic DIR_DOWN = 1'b0;
   localparam logic DIR_UP   = 1'b1;

   localparam logic [1:0] MOTOR_STOP = 2'd0;
   localparam logic [1:0] MOTOR_UP   = 2'd1;
   localparam logic [1:0] MOTOR_DOWN = 2'd2;

   localparam logic [2:0] MODE_CODE_START  = 3'd0;
   localparam logic [2:0] MODE_CODE_IDLE   = 3'd1;
   localparam logic [2:0] MODE_CODE_MOVING = 3'd2;
   localparam logic [2:0] MODE_CODE_DOOR   = 3'd3;
   localparam logic [2:0] MODE_CODE_EMERG  = 3'd4;

   typedef logic [FLOORS-1:0]      floor_vec_type;
   typedef logic [FLOOR_IDX_W-1:0] floor_idx_type;

   typedef enum logic [4:0] {
      MODE_START  = 5'b00001,
      MODE_IDLE   = 5'b00010,
      MODE_MOVING = 5'b00100,
      MODE_DOOR   = 5'b01000,
      MODE_EMERG  = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [3:0] floor_sensors;
      logic       stop_button;
      logic       obstruction;
      logic [3:0] hall_up_buttons;
      logic [3:0] hall_down_buttons;
      logic [3:0] cab_buttons;
   } req_item_type;

   typedef struct packed {
      logic [1:0] motor_command;
      logic       door_open;
      logic       stop_lamp;
      logic [1:0] floor_lamp;
      logic [3:0] hall_up_lamps;
      logic [3:0] hall_down_lamps;
      logic [3:0] cab_lamps;
      logic [2:0] controller_mode;
   } rsp_item_type;

   typedef struct packed {
      mode_type      mode;
      logic          travel_dir;
      logic          prior_dir;
      logic          at_floor;
      floor_idx_type floor_now;
      floor_idx_type floor_last;
      logic          above_last;
      logic [TICKS_W-1:0] countdown;
      floor_vec_type up_orders;
      floor_vec_type down_orders;
      floor_vec_type cab_orders;
      logic          door_flag;
      logic          stop_lamp_flag;
   } elc_state_type;

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] c;
      unique case (m)
         MODE_START:  c = MODE_CODE_START;
         MODE_MOVING: c = MODE_CODE_MOVING;
         MODE_DOOR:   c = MODE_CODE_DOOR;
         MODE_EMERG:  c = MODE_CODE_EMERG;
         default:     c = MODE_CODE_IDLE;
      endcase
      return c;
   endfunction

   function automatic logic orders_below(input floor_vec_type ord, input floor_idx_type f);
      floor_vec_type m;
      m = (floor_vec_type'(1) << f) - floor_vec_type'(1);
      return (ord & m) != '0;
   endfunction

   function automatic logic orders_above(input floor_vec_type ord, input floor_idx_type f);
      floor_vec_type m;
      m = (floor_vec_type'(2) << f) - floor_vec_type'(1);
      return (ord & ~m) != '0;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/elc_step.sv =====
// elc_step: next-state and result logic for one tick of the car controller
// depends on elc_pkg
`default_nettype none

module elc_step import elc_pkg::*; (
   input  elc_state_type      state_cur,
   input  req_item_type       item,
   input  logic [TICKS_W-1:0] door_ticks,
   output elc_state_type      state_nxt,
   output rsp_item_type       rsp
);

   elc_state_type n;
   floor_vec_type sensors;
   floor_vec_type ord_all;
   floor_idx_type low_idx;
   logic          low_found;
   logic          serve;
   logic          dir_bit;
   logic          stop;
   logic          obst;

   function automatic elc_state_type go_emergency(input elc_state_type s);
      elc_state_type r;
      r = s;
      r.stop_lamp_flag = 1'b1;
      r.prior_dir      = s.travel_dir;
      r.up_orders      = '0;
      r.down_orders    = '0;
      r.cab_orders     = '0;
      if (s.at_floor) begin
         r.door_flag = 1'b1;
      end
      r.mode = MODE_EMERG;
      return r;
   endfunction

   function automatic elc_state_type go_door(input elc_state_type s,
                                             input logic [TICKS_W-1:0] t);
      elc_state_type r;
      r = s;
      r.prior_dir = s.travel_dir;
      r.door_flag = 1'b1;
      r.countdown = t;
      r.mode      = MODE_DOOR;
      return r;
   endfunction

   function automatic elc_state_type go_moving(input elc_state_type s, input logic d);
      elc_state_type r;
      r = s;
      r.travel_dir = d;
      r.mode       = MODE_MOVING;
      return r;
   endfunction

   function automatic elc_state_type latch(input elc_state_type s, input req_item_type i);
      elc_state_type r;
      r = s;
      r.up_orders   = s.up_orders   | floor_vec_type'(i.hall_up_buttons);
      r.down_orders = s.down_orders | floor_vec_type'(i.hall_down_buttons);
      r.cab_orders  = s.cab_orders  | floor_vec_type'(i.cab_buttons);
      return r;
   endfunction

   function automatic elc_state_type run_count(input elc_state_type s, input logic ob,
                                               input logic [TICKS_W-1:0] t);
      elc_state_type r;
      r = s;
      if (ob) begin
         r.countdown = t;
      end else if (s.countdown != '0) begin
         r.countdown = s.countdown - TICKS_W'(1);
      end
      return r;
   endfunction

   // lowest active sensor
   always_comb begin
      sensors   = floor_vec_type'(item.floor_sensors);
      low_found = 1'b0;
      low_idx   = '0;
      for (int f = FLOORS - 1; f >= 0; f--) begin
         if (sensors[f]) begin
            low_found = 1'b1;
            low_idx   = floor_idx_type'(f);
         end
      end
   end

   always_comb begin
      stop    = item.stop_button;
      obst    = item.obstruction;
      n       = state_cur;
      serve   = 1'b1;
      ord_all = '0;
      dir_bit = 1'b0;
      unique case (state_cur.mode)
         MODE_START: begin
            if (low_found) begin
               n.floor_now   = low_idx;
               n.floor_last  = low_idx;
               n.at_floor    = 1'b1;
               n.prior_dir   = DIR_DOWN;
               n.up_orders   = '0;
               n.down_orders = '0;
               n.cab_orders  = '0;
               n.countdown   = '0;
               n.mode        = MODE_IDLE;
            end
         end
         MODE_MOVING: begin
            if (stop) begin
               n = go_emergency(n);
            end else begin
               n = latch(n, item);
               if (!low_found) begin
                  n.at_floor = 1'b0;
               end else begin
                  n.at_floor   = 1'b1;
                  n.floor_now  = low_idx;
                  n.floor_last = low_idx;
                  n.above_last = (n.travel_dir == DIR_UP);
                  ord_all      = n.up_orders | n.down_orders | n.cab_orders;
                  dir_bit      = (n.travel_dir == DIR_UP) ? n.up_orders[low_idx]
                                                         : n.down_orders[low_idx];
                  if (ord_all[low_idx] &&
                      ((n.travel_dir == DIR_UP && !orders_above(ord_all, low_idx)) ||
                       (n.travel_dir == DIR_DOWN && !orders_below(ord_all, low_idx)) ||
                       dir_bit || n.cab_orders[low_idx])) begin
                     n = go_door(n, door_ticks);
                  end
               end
            end
         end
         MODE_DOOR: begin
            if (stop) begin
               n = go_emergency(n);
            end else begin
               n = latch(n, item);
               n = run_count(n, obst, door_ticks);
               if (n.countdown == '0) begin
                  n.up_orders[n.floor_now]   = 1'b0;
                  n.down_orders[n.floor_now] = 1'b0;
                  n.cab_orders[n.floor_now]  = 1'b0;
                  n.door_flag = 1'b0;
                  ord_all = n.up_orders | n.down_orders | n.cab_orders;
                  if (ord_all == '0) begin
                     n.mode = MODE_IDLE;
                  end else if (n.prior_dir == DIR_UP) begin
                     n = go_moving(n, orders_above(ord_all, n.floor_now) ? DIR_UP : DIR_DOWN);
                  end else begin
                     n = go_moving(n, orders_below(ord_all, n.floor_now) ? DIR_DOWN : DIR_UP);
                  end
               end
            end
         end
         MODE_EMERG: begin
            if (!stop) begin
               n.stop_lamp_flag = 1'b0;
               if (n.at_floor) begin
                  n.countdown = door_ticks;
               end
               n.mode = MODE_IDLE;
            end
         end
         default: begin
            // pending door time is served first
            if (state_cur.countdown != '0) begin
               if (stop) begin
                  n     = go_emergency(n);
                  serve = 1'b0;
               end else begin
                  n = latch(n, item);
                  n = run_count(n, obst, door_ticks);
                  if (n.countdown != '0) begin
                     serve = 1'b0;
                  end
               end
            end
            if (serve) begin
               n.door_flag = 1'b0;
               if (stop) begin
                  n = go_emergency(n);
               end else begin
                  n = latch(n, item);
                  ord_all = n.up_orders | n.down_orders | n.cab_orders;
                  if (n.at_floor) begin
                     if (ord_all[n.floor_now]) begin
                        n = go_door(n, door_ticks);
                     end else if (orders_below(ord_all, n.floor_now)) begin
                        n = go_moving(n, DIR_DOWN);
                     end else if (orders_above(ord_all, n.floor_now)) begin
                        n = go_moving(n, DIR_UP);
                     end
                  end else begin
                     if (ord_all[n.floor_last]) begin
                        n = go_moving(n, n.above_last ? DIR_DOWN : DIR_UP);
                     end else if (orders_below(ord_all, n.floor_last)) begin
                        n = go_moving(n, DIR_DOWN);
                     end else if (orders_above(ord_all, n.floor_last)) begin
                        n = go_moving(n, DIR_UP);
                     end
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      state_nxt = n;
      priority if (n.mode == MODE_START) begin
         rsp.motor_command = MOTOR_DOWN;
      end else if (n.mode == MODE_MOVING) begin
         rsp.motor_command = (n.travel_dir == DIR_UP) ? MOTOR_UP : MOTOR_DOWN;
      end else begin
         rsp.motor_command = MOTOR_STOP;
      end
      rsp.door_open       = n.door_flag;
      rsp.stop_lamp       = n.stop_lamp_flag;
      rsp.floor_lamp      = 2'(n.floor_last);
      rsp.hall_up_lamps   = 4'(n.up_orders);
      rsp.hall_down_lamps = 4'(n.down_orders);
      rsp.cab_lamps       = 4'(n.cab_orders);
      rsp.controller_mode = mode_code(n.mode);
   end

endmodule

`default_nettype wire

// ===== rtl/elevator_controller.sv =====
// elevator_controller: top level with item register, car state and result register
// depends on elc_pkg and elc_step
//
//   channel  ports                         direction  payload
//   req      req_valid req_ready req_item  in         req_item_type
//   rsp      rsp_valid rsp_ready rsp_item  out        rsp_item_type
//   csr      csr_valid csr_ready csr_data  in         door open ticks, 16 bits
//
// one item per cycle sustained while the result is not stalled; an accepted item
// passes the item register, then the result register around elc_step, to rsp_valid
// synchronous reset puts the car in start-up descent, door time 3000 ticks
// a stalled result holds the item register, and req_ready drops once it is full
// csr_ready is always high
`default_nettype none

module elevator_controller import elc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_item_type       req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_item_type       rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [TICKS_W-1:0] csr_data
);

   logic               in_valid_ff, in_valid_in;
   req_item_type       in_item_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff;
   elc_state_type      state_ff, state_in;
   rsp_item_type       rsp_calc;
   logic [TICKS_W-1:0] door_ticks_ff;
   logic               advance;

   elc_step u_step (
      .state_cur  (state_ff),
      .item       (in_item_ff),
      .door_ticks (door_ticks_ff),
      .state_nxt  (state_in),
      .rsp        (rsp_calc)
   );

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = out_valid_ff;
   assign rsp_item    = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         door_ticks_ff <= DOOR_TICKS_RESET;
         state_ff      <= '{mode: MODE_START, travel_dir: DIR_DOWN, prior_dir: DIR_DOWN,
                            default: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            door_ticks_ff <= csr_data;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= rsp_calc;
      end
   end

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("computed item did not reach the result register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("waiting item lost while result stalled");

   a_lamp_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff.stop_lamp_flag == (state_ff.mode == MODE_EMERG))
      else $error("stop lamp out of step with emergency mode");

   a_emerg_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_EMERG) |->
         (state_ff.up_orders == '0 && state_ff.down_orders == '0 &&
          state_ff.cab_orders == '0))
      else $error("orders latched during emergency");

   a_motor_mode: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.motor_command != MOTOR_STOP) |->
         (out_item_ff.controller_mode == MODE_CODE_START ||
          out_item_ff.controller_mode == MODE_CODE_MOVING))
      else $error("motor driven outside start-up or moving");

endmodule

`default_nettype wire
